/* rtl/core/flc_pkg.sv */
// ----------------------------------------------------------------------------
// flc_pkg
// Shared types and constants of the flashlight mode controller.
// ----------------------------------------------------------------------------
package flc_pkg;

  // Light levels as shown on light_level
  localparam logic [1:0] LVL_OFF  = 2'd0;
  localparam logic [1:0] LVL_LOW  = 2'd1;
  localparam logic [1:0] LVL_MED  = 2'd2;
  localparam logic [1:0] LVL_HIGH = 2'd3;

  // Toggles in one overheat blink sequence
  localparam logic [2:0] BLINK_TOGGLES = 3'd6;

  // Configuration register map (index = paddr[4:2])
  localparam int unsigned APB_AW = 5;
  localparam logic [2:0] REG_LONG_PRESS  = 3'd0;
  localparam logic [2:0] REG_STROBE_HALF = 3'd1;
  localparam logic [2:0] REG_OVERTEMP    = 3'd2;
  localparam logic [2:0] REG_TEMP_PERIOD = 3'd3;
  localparam logic [2:0] REG_BLINK       = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_LONG_PRESS  = 8'd15;
  localparam logic [7:0] RST_STROBE_HALF = 8'd2;
  localparam logic [7:0] RST_OVERTEMP    = 8'd200;
  localparam logic [7:0] RST_TEMP_PERIOD = 8'd153;
  localparam logic [7:0] RST_BLINK       = 8'd15;

  // Button press tracking
  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_TIMING = 2'd1,
    PH_HELD   = 2'd2
  } press_phase_e;

  typedef struct packed {
    logic [7:0] long_press_ticks;
    logic [7:0] strobe_half_ticks;
    logic [7:0] overtemp_threshold;
    logic [7:0] temp_period_ticks;
    logic [7:0] blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] light_level;
    logic       drive_enable;
    logic       drive_high_current;
    logic       dim_pwm_on;
    logic       power_hold;
    logic       strobe_active;
    logic       overheat_blinking;
  } result_t;

endpackage

/* rtl/core/flc_if.sv */
// ----------------------------------------------------------------------------
// flc_if
// Valid/ready channels: tick input and result output.
// ----------------------------------------------------------------------------
interface flc_in_if;
  logic       valid;
  logic       ready;
  logic       button_down;
  logic [7:0] temp_reading;

  modport source (output valid, output button_down, output temp_reading, input ready);
  modport sink   (input valid, input button_down, input temp_reading, output ready);
endinterface

interface flc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] light_level;
  logic       drive_enable;
  logic       drive_high_current;
  logic       dim_pwm_on;
  logic       power_hold;
  logic       strobe_active;
  logic       overheat_blinking;

  modport source (
    output valid, output light_level, output drive_enable, output drive_high_current,
    output dim_pwm_on, output power_hold, output strobe_active, output overheat_blinking,
    input ready
  );
  modport sink (
    input valid, input light_level, input drive_enable, input drive_high_current,
    input dim_pwm_on, input power_hold, input strobe_active, input overheat_blinking,
    output ready
  );
endinterface

/* rtl/core/flc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// flc_cfg_regs
// APB register file holding the five 8-bit controller settings.
// ----------------------------------------------------------------------------
module flc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [flc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output flc_pkg::cfg_t              cfg_o
);
  import flc_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  // register writes, out-of-map indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks   <= RST_LONG_PRESS;
      cfg_q.strobe_half_ticks  <= RST_STROBE_HALF;
      cfg_q.overtemp_threshold <= RST_OVERTEMP;
      cfg_q.temp_period_ticks  <= RST_TEMP_PERIOD;
      cfg_q.blink_ticks        <= RST_BLINK;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LONG_PRESS:  cfg_q.long_press_ticks   <= pwdata[7:0];
        REG_STROBE_HALF: cfg_q.strobe_half_ticks  <= pwdata[7:0];
        REG_OVERTEMP:    cfg_q.overtemp_threshold <= pwdata[7:0];
        REG_TEMP_PERIOD: cfg_q.temp_period_ticks  <= pwdata[7:0];
        REG_BLINK:       cfg_q.blink_ticks        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_LONG_PRESS:  prdata[7:0] = cfg_q.long_press_ticks;
      REG_STROBE_HALF: prdata[7:0] = cfg_q.strobe_half_ticks;
      REG_OVERTEMP:    prdata[7:0] = cfg_q.overtemp_threshold;
      REG_TEMP_PERIOD: prdata[7:0] = cfg_q.temp_period_ticks;
      REG_BLINK:       prdata[7:0] = cfg_q.blink_ticks;
      default:         prdata      = '0;
    endcase
  end

endmodule

/* rtl/core/flc_core.sv */
// ----------------------------------------------------------------------------
// flc_core
// Per-tick state update: button, strobe, temperature latch, overheat blink.
// ----------------------------------------------------------------------------
module flc_core #(
  parameter int unsigned TimerBits = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             button_down_i,
  input  logic [7:0]       temp_reading_i,
  input  flc_pkg::cfg_t    cfg_i,
  output flc_pkg::result_t result_o
);
  import flc_pkg::*;

  // compare width: wide enough for both timer and 8-bit threshold
  localparam int unsigned CW = (TimerBits > 8) ? TimerBits : 8;

  typedef logic [TimerBits-1:0] tmr_t;

  function automatic tmr_t sat_inc(input tmr_t t);
    return (t == '1) ? t : tmr_t'(t + 1'b1);
  endfunction

  logic [1:0]   level_now_q, level_now_d;
  logic [1:0]   level_next_q, level_next_d;
  logic         strobe_mode_q, strobe_mode_d;
  logic         drive_pin_q, drive_pin_d;
  logic         hold_pin_q, hold_pin_d;
  logic         button_prev_q, button_prev_d;
  press_phase_e press_phase_q, press_phase_d;
  tmr_t         press_timer_q, press_timer_d;
  tmr_t         strobe_timer_q, strobe_timer_d;
  tmr_t         temp_timer_q, temp_timer_d;
  logic [7:0]   temp_latched_q, temp_latched_d;
  logic         temp_seen_q, temp_seen_d;
  logic [2:0]   blink_count_q, blink_count_d;
  tmr_t         blink_timer_q, blink_timer_d;

  logic         do_step, do_toggle;

  // next state for one tick
  always_comb begin
    level_now_d    = level_now_q;
    level_next_d   = level_next_q;
    strobe_mode_d  = strobe_mode_q;
    drive_pin_d    = drive_pin_q;
    hold_pin_d     = hold_pin_q;
    button_prev_d  = button_prev_q;
    press_phase_d  = press_phase_q;
    press_timer_d  = press_timer_q;
    strobe_timer_d = strobe_timer_q;
    temp_timer_d   = temp_timer_q;
    temp_latched_d = temp_latched_q;
    temp_seen_d    = temp_seen_q;
    blink_count_d  = blink_count_q;
    blink_timer_d  = blink_timer_q;
    do_step        = 1'b0;
    do_toggle      = 1'b0;

    if (step_i) begin
      if (blink_count_q != 3'd0) begin
        // blink sequence only; everything else but the button history holds
        blink_timer_d = sat_inc(blink_timer_q);
        if (CW'(blink_timer_d) >= CW'(cfg_i.blink_ticks)) begin
          blink_timer_d = '0;
          drive_pin_d   = ~drive_pin_q;
          blink_count_d = blink_count_q - 3'd1;
          if (blink_count_d == 3'd0) begin
            level_now_d  = LVL_LOW;
            level_next_d = LVL_OFF;
            drive_pin_d  = 1'b0;
          end
        end
      end else begin
        // button press tracking
        unique case (press_phase_q)
          PH_WAIT: begin
            if (button_down_i && !button_prev_q) begin
              press_phase_d = PH_TIMING;
              press_timer_d = '0;
            end
          end
          PH_TIMING: begin
            if (!button_down_i) begin
              do_step       = 1'b1;
              press_phase_d = PH_WAIT;
            end else begin
              press_timer_d = sat_inc(press_timer_q);
              if (CW'(press_timer_d) > CW'(cfg_i.long_press_ticks)) begin
                if (level_now_q != LVL_OFF) do_toggle = 1'b1;
                else                        do_step   = 1'b1;
                press_phase_d = PH_HELD;
              end
            end
          end
          PH_HELD: begin
            if (!button_down_i) press_phase_d = PH_WAIT;
          end
          default: press_phase_d = PH_WAIT;
        endcase

        // level step
        if (do_step) begin
          level_now_d = level_next_q;
          drive_pin_d = (level_next_q == LVL_MED) || (level_next_q == LVL_HIGH);
          if (level_next_q == LVL_OFF) begin
            strobe_mode_d = 1'b0;
            hold_pin_d    = 1'b0;
            level_next_d  = LVL_LOW;
          end else begin
            if (level_next_q == LVL_LOW) hold_pin_d = 1'b1;
            level_next_d = level_next_q + 2'd1;
          end
        end

        // strobe toggle on long press
        if (do_toggle) begin
          if (strobe_mode_q) begin
            strobe_mode_d = 1'b0;
            drive_pin_d   = (level_now_q == LVL_MED) || (level_now_q == LVL_HIGH);
          end else begin
            strobe_mode_d = 1'b1;
          end
        end

        // strobe drive flashing
        strobe_timer_d = sat_inc(strobe_timer_q);
        if ((level_now_d > LVL_LOW) && strobe_mode_d &&
            (CW'(strobe_timer_d) >= CW'(cfg_i.strobe_half_ticks))) begin
          drive_pin_d    = ~drive_pin_d;
          strobe_timer_d = '0;
        end

        // temperature latch
        if (!temp_seen_q) begin
          temp_seen_d    = 1'b1;
          temp_latched_d = temp_reading_i;
          temp_timer_d   = '0;
        end else begin
          temp_timer_d = sat_inc(temp_timer_q);
          if (CW'(temp_timer_d) >= CW'(cfg_i.temp_period_ticks)) begin
            temp_latched_d = temp_reading_i;
            temp_timer_d   = '0;
          end
        end

        // overheat check
        if (((level_now_d == LVL_MED) || (level_now_d == LVL_HIGH)) &&
            (temp_latched_d > cfg_i.overtemp_threshold)) begin
          level_now_d   = LVL_MED;
          drive_pin_d   = 1'b1;
          blink_count_d = BLINK_TOGGLES;
          blink_timer_d = '0;
        end
      end
      button_prev_d = button_down_i;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_now_q    <= LVL_OFF;
      level_next_q   <= LVL_LOW;
      strobe_mode_q  <= 1'b0;
      drive_pin_q    <= 1'b0;
      hold_pin_q     <= 1'b1;
      button_prev_q  <= 1'b0;
      press_phase_q  <= PH_WAIT;
      press_timer_q  <= '0;
      strobe_timer_q <= '0;
      temp_timer_q   <= '0;
      temp_latched_q <= '0;
      temp_seen_q    <= 1'b0;
      blink_count_q  <= '0;
      blink_timer_q  <= '0;
    end else begin
      level_now_q    <= level_now_d;
      level_next_q   <= level_next_d;
      strobe_mode_q  <= strobe_mode_d;
      drive_pin_q    <= drive_pin_d;
      hold_pin_q     <= hold_pin_d;
      button_prev_q  <= button_prev_d;
      press_phase_q  <= press_phase_d;
      press_timer_q  <= press_timer_d;
      strobe_timer_q <= strobe_timer_d;
      temp_timer_q   <= temp_timer_d;
      temp_latched_q <= temp_latched_d;
      temp_seen_q    <= temp_seen_d;
      blink_count_q  <= blink_count_d;
      blink_timer_q  <= blink_timer_d;
    end
  end

  // result for this tick, taken from post-tick state
  always_comb begin
    result_o.light_level        = level_now_d;
    result_o.drive_enable       = drive_pin_d;
    result_o.drive_high_current = (level_now_d == LVL_HIGH);
    result_o.dim_pwm_on         = (level_now_d == LVL_LOW);
    result_o.power_hold         = hold_pin_d;
    result_o.strobe_active      = strobe_mode_d;
    result_o.overheat_blinking  = (blink_count_d != 3'd0);
  end

`ifndef NO_ASSERTIONS
  // blinking always shows medium
  a_blink_med: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blink_count_q != 3'd0) |-> (level_now_q == LVL_MED))
    else $error("blink sequence active while level is not medium");

  // end of blinking forces low and arms the next press to turn off
  a_blink_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((blink_count_q == 3'd1) && (blink_count_d == 3'd0)) |=>
      ((level_now_q == LVL_LOW) && (level_next_q == LVL_OFF) && !drive_pin_q))
    else $error("blink end did not force low level");

  // strobe never stays selected with the light off
  a_off_solid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_now_q == LVL_OFF) |-> !strobe_mode_q)
    else $error("strobe selected while light is off");

  // state only moves on an accepted tick
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(level_now_q) && $stable(press_timer_q) && $stable(blink_count_q)))
    else $error("state changed without a tick");
`endif

endmodule

/* rtl/core/flashlight_mode_controller_top.sv */
// ----------------------------------------------------------------------------
// flashlight_mode_controller_top
// Flashlight mode controller: one tick in, one result out, APB settings.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  in_i     | in  | valid/ready        | button_down, temp_reading
//  out_o    | out | valid/ready        | light_level, drive_*, dim_pwm_on, ...
//  apb      | in  | psel/penable/pready| paddr[4:2] register index, pwdata[7:0]
//
//  One tick per clock sustained while the output is not stalled; a result beat is
//  offered once its tick beat has passed the input register and then the state
//  update into the result register.
//  Reset clears the mode state and loads the register defaults.
//  A stalled output beat holds the tick in the input register; no beat is lost.
// ----------------------------------------------------------------------------
module flashlight_mode_controller_top #(
  parameter int unsigned TimerBits = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  flc_in_if.sink                     in_i,
  flc_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [flc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import flc_pkg::*;

  cfg_t       cfg;
  result_t    result;
  result_t    out_q;
  logic       out_valid_q;
  logic       in_valid_q;
  logic       in_btn_q;
  logic [7:0] in_temp_q;
  logic       advance;
  logic       step;

  flc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline flow control
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign step       = in_valid_q && advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_btn_q  <= in_i.button_down;
      in_temp_q <= in_i.temp_reading;
    end
  end

  flc_core #(
    .TimerBits (TimerBits)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .button_down_i  (in_btn_q),
    .temp_reading_i (in_temp_q),
    .cfg_i          (cfg),
    .result_o       (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.light_level        = out_q.light_level;
  assign out_o.drive_enable       = out_q.drive_enable;
  assign out_o.drive_high_current = out_q.drive_high_current;
  assign out_o.dim_pwm_on         = out_q.dim_pwm_on;
  assign out_o.power_hold         = out_q.power_hold;
  assign out_o.strobe_active      = out_q.strobe_active;
  assign out_o.overheat_blinking  = out_q.overheat_blinking;

`ifndef NO_ASSERTIONS
  // a pending tick with a free result slot yields a result beat next cycle
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("pending tick did not reach the result register");

  // a stalled result beat blocks the core
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !step)
    else $error("core stepped while result beat was stalled");

  // a stalled result beat keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(out_q))
    else $error("stalled result beat changed");
`endif

endmodule
